/* src/adsr_pkg.sv */
package adsr_pkg;

    // Default field widths
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int INDEX_WIDTH_DEF  = 24;

    // Gain is unsigned Q0.16; the quotient carries one more bit for exactly 1.0
    localparam int GAIN_W  = 16;
    localparam int QUOT_W  = GAIN_W + 1;
    localparam logic [GAIN_W-1:0] GAIN_SUSTAIN = 16'd52428;  // floor(0.8 * 2^16)
    localparam logic [GAIN_W-1:0] GAIN_MAX     = 16'hFFFF;
    localparam logic [GAIN_W-1:0] GAIN_ZERO    = 16'h0000;

    // Configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 8'd3;

    // Envelope segment codes
    localparam int SEG_W = 3;
    typedef enum logic [SEG_W-1:0] {
        SEG_ATTACK  = 3'd0,
        SEG_DECAY   = 3'd1,
        SEG_SUSTAIN = 3'd2,
        SEG_RELEASE = 3'd3,
        SEG_DONE    = 3'd4
    } t_segment;

endpackage

/* src/adsr_in_if.sv */
interface adsr_in_if #(
    parameter int SAMPLE_WIDTH = adsr_pkg::SAMPLE_WIDTH_DEF,
    parameter int INDEX_WIDTH  = adsr_pkg::INDEX_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic [INDEX_WIDTH-1:0]         sample_index;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, sample_index, sample_in, input ready);
    modport sink   (input valid, sample_index, sample_in, output ready);
endinterface

/* src/adsr_out_if.sv */
interface adsr_out_if #(
    parameter int SAMPLE_WIDTH = adsr_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic [adsr_pkg::SEG_W-1:0]     segment;

    modport source (output valid, sample_out, segment, input ready);
    modport sink   (input valid, sample_out, segment, output ready);
endinterface

/* src/adsr_cfg_if.sv */
interface adsr_cfg_if #(
    parameter int INDEX_WIDTH = adsr_pkg::INDEX_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic [adsr_pkg::CFG_IDX_W-1:0] index;
    logic [INDEX_WIDTH-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/adsr_cfg_regs.sv */
module adsr_cfg_regs #(
    parameter int INDEX_WIDTH = adsr_pkg::INDEX_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    adsr_cfg_if.sink               i_cfg,
    output logic [INDEX_WIDTH-1:0] o_attack_len,
    output logic [INDEX_WIDTH-1:0] o_decay_len,
    output logic [INDEX_WIDTH-1:0] o_sustain_len,
    output logic [INDEX_WIDTH-1:0] o_release_len
);

    logic [INDEX_WIDTH-1:0] r_attack_len;
    logic [INDEX_WIDTH-1:0] r_decay_len;
    logic [INDEX_WIDTH-1:0] r_sustain_len;
    logic [INDEX_WIDTH-1:0] r_release_len;

    // Writes always complete; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_len  <= '0;
            r_decay_len   <= '0;
            r_sustain_len <= '0;
            r_release_len <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                adsr_pkg::CFG_ATTACK:  r_attack_len  <= i_cfg.data;
                adsr_pkg::CFG_DECAY:   r_decay_len   <= i_cfg.data;
                adsr_pkg::CFG_SUSTAIN: r_sustain_len <= i_cfg.data;
                adsr_pkg::CFG_RELEASE: r_release_len <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign o_attack_len  = r_attack_len;
    assign o_decay_len   = r_decay_len;
    assign o_sustain_len = r_sustain_len;
    assign o_release_len = r_release_len;

endmodule

/* src/adsr_seg_decode.sv */
// Three stages: segment end sums, compares, then numerator/denominator select.
module adsr_seg_decode #(
    parameter int SAMPLE_WIDTH = adsr_pkg::SAMPLE_WIDTH_DEF,
    parameter int INDEX_WIDTH  = adsr_pkg::INDEX_WIDTH_DEF,
    localparam int DW          = INDEX_WIDTH + 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [INDEX_WIDTH-1:0]         i_index,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic [INDEX_WIDTH-1:0]         i_attack_len,
    input  logic [INDEX_WIDTH-1:0]         i_decay_len,
    input  logic [INDEX_WIDTH-1:0]         i_sustain_len,
    input  logic [INDEX_WIDTH-1:0]         i_release_len,
    output logic                           o_valid,
    output logic [DW-1:0]                  o_num,
    output logic [DW-1:0]                  o_den,
    output logic [adsr_pkg::SEG_W-1:0]     o_seg,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample
);

    localparam int W = INDEX_WIDTH;

    // stage 1
    logic                           r1_v;
    logic [W-1:0]                   r1_i;
    logic signed [SAMPLE_WIDTH-1:0] r1_s;
    logic [W-1:0]                   r1_a;
    logic [W-1:0]                   r1_slen;
    logic [W:0]                     r1_ad;
    logic [W:0]                     r1_sr;
    logic [DW-1:0]                  r1_d5;
    logic [DW-1:0]                  r1_r5;
    // stage 2
    logic                           r2_v;
    logic [W-1:0]                   r2_i;
    logic signed [SAMPLE_WIDTH-1:0] r2_s;
    logic [W-1:0]                   r2_a;
    logic                           r2_lt_a;
    logic                           r2_lt_d;
    logic [W+1:0]                   r2_es;
    logic [W+1:0]                   r2_er;
    logic [DW-1:0]                  r2_d5;
    logic [DW-1:0]                  r2_d5a;
    logic [DW-1:0]                  r2_r5;
    // stage 3
    logic                           r3_v;
    logic signed [SAMPLE_WIDTH-1:0] r3_s;
    logic [DW-1:0]                  r3_num;
    logic [DW-1:0]                  r3_den;
    logic [adsr_pkg::SEG_W-1:0]     r3_seg;

    logic                           lt_s;
    logic                           lt_r;
    logic [W+1:0]                   rel_left;
    logic [DW-1:0]                  n_num;
    logic [DW-1:0]                  n_den;
    adsr_pkg::t_segment             n_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // 5x lengths as shift-and-add; end sums kept at full precision
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_i    <= i_index;
            r1_s    <= i_sample;
            r1_a    <= i_attack_len;
            r1_slen <= i_sustain_len;
            r1_ad   <= {1'b0, i_attack_len} + {1'b0, i_decay_len};
            r1_sr   <= {1'b0, i_sustain_len} + {1'b0, i_release_len};
            r1_d5   <= {1'b0, i_decay_len, 2'b00} + {3'b000, i_decay_len};
            r1_r5   <= {1'b0, i_release_len, 2'b00} + {3'b000, i_release_len};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_i    <= r1_i;
            r2_s    <= r1_s;
            r2_a    <= r1_a;
            r2_lt_a <= r1_i < r1_a;
            r2_lt_d <= {1'b0, r1_i} < r1_ad;
            r2_es   <= {1'b0, r1_ad} + {2'b00, r1_slen};
            r2_er   <= {1'b0, r1_ad} + {1'b0, r1_sr};
            r2_d5   <= r1_d5;
            r2_d5a  <= r1_d5 + {3'b000, r1_a};
            r2_r5   <= r1_r5;
        end
    end

    // decay:   5D - (i - A)        = (5D + A) - i
    // release: 4 * (R - (i - Es))  = 4 * (Er - i)
    assign lt_s     = {2'b00, r2_i} < r2_es;
    assign lt_r     = {2'b00, r2_i} < r2_er;
    assign rel_left = r2_er - {2'b00, r2_i};

    always_comb begin
        n_num = '0;
        n_den = '0;
        priority if (r2_lt_a) begin
            n_seg = adsr_pkg::SEG_ATTACK;
            n_num = {3'b000, r2_i};
            n_den = {3'b000, r2_a};
        end else if (r2_lt_d) begin
            n_seg = adsr_pkg::SEG_DECAY;
            n_num = r2_d5a - {3'b000, r2_i};
            n_den = r2_d5;
        end else if (lt_s) begin
            n_seg = adsr_pkg::SEG_SUSTAIN;
        end else if (lt_r) begin
            n_seg = adsr_pkg::SEG_RELEASE;
            n_num = {rel_left[W:0], 2'b00};
            n_den = r2_r5;
        end else begin
            n_seg = adsr_pkg::SEG_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_s   <= r2_s;
            r3_num <= n_num;
            r3_den <= n_den;
            r3_seg <= n_seg;
        end
    end

    assign o_valid  = r3_v;
    assign o_num    = r3_num;
    assign o_den    = r3_den;
    assign o_seg    = r3_seg;
    assign o_sample = r3_s;

endmodule

/* src/adsr_gain_div.sv */
// Restoring divider, one quotient bit per stage: q = floor(num * 2^16 / den).
// Requires num <= den; the first stage compares without a shift.
module adsr_gain_div #(
    parameter int DW    = adsr_pkg::INDEX_WIDTH_DEF + 3,
    parameter int TAG_W = adsr_pkg::SEG_W + adsr_pkg::SAMPLE_WIDTH_DEF,
    localparam int QW   = adsr_pkg::QUOT_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [DW-1:0]    i_num,
    input  logic [DW-1:0]    i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [QW-1:0]    o_quot,
    output logic [TAG_W-1:0] o_tag
);

    logic             r_v   [QW];
    logic [DW-1:0]    r_rem [QW];
    logic [DW-1:0]    r_den [QW];
    logic [QW-1:0]    r_q   [QW];
    logic [TAG_W-1:0] r_tag [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic             v_in;
        logic [DW-1:0]    rem_in;
        logic [DW-1:0]    den_in;
        logic [QW-1:0]    q_in;
        logic [TAG_W-1:0] tag_in;
        logic [DW:0]      trial;
        logic             ge;
        logic [DW:0]      diff;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign rem_in = i_num;
            assign den_in = i_den;
            assign q_in   = '0;
            assign tag_in = i_tag;
            assign trial  = {1'b0, rem_in};
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign q_in   = r_q[k-1];
            assign tag_in = r_tag[k-1];
            assign trial  = {rem_in, 1'b0};
        end

        assign ge   = trial >= {1'b0, den_in};
        assign diff = trial - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        // remainder stays below den, so it fits DW bits
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                r_den[k] <= den_in;
                r_q[k]   <= {q_in[QW-2:0], ge};
                r_tag[k] <= tag_in;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quot  = r_q[QW-1];
    assign o_tag   = r_tag[QW-1];

endmodule

/* src/adsr_scale.sv */
// Gain select and sample multiply, one register stage.
module adsr_scale #(
    parameter int SAMPLE_WIDTH = adsr_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [adsr_pkg::QUOT_W-1:0]    i_quot,
    input  logic [adsr_pkg::SEG_W-1:0]     i_seg,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                           o_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample,
    output logic [adsr_pkg::SEG_W-1:0]     o_seg
);

    localparam int GW = adsr_pkg::GAIN_W;
    localparam int PW = SAMPLE_WIDTH + GW + 1;

    logic [GW-1:0]          gain;
    logic signed [GW:0]     gain_s;
    logic                   r_v;
    logic signed [PW-1:0]   r_prod;
    logic [adsr_pkg::SEG_W-1:0] r_seg;

    always_comb begin
        unique case (i_seg)
            adsr_pkg::SEG_ATTACK:  gain = i_quot[GW-1:0];
            // exact 1.0 at decay start is held just below
            adsr_pkg::SEG_DECAY:   gain = i_quot[GW] ? adsr_pkg::GAIN_MAX : i_quot[GW-1:0];
            adsr_pkg::SEG_SUSTAIN: gain = adsr_pkg::GAIN_SUSTAIN;
            adsr_pkg::SEG_RELEASE: gain = i_quot[GW-1:0];
            default:               gain = adsr_pkg::GAIN_ZERO;
        endcase
    end

    assign gain_s = $signed({1'b0, gain});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PW'(i_sample) * PW'(gain_s);
            r_seg  <= i_seg;
        end
    end

    // arithmetic shift by 16 rounds toward minus infinity; gain < 1 so it fits
    assign o_valid  = r_v;
    assign o_sample = r_prod[GW+SAMPLE_WIDTH-1:GW];
    assign o_seg    = r_seg;

endmodule

/* src/adsr_envelope_gain.sv */
// ADSR envelope gain stage.
// i_smp carries one audio sample (signed Q1.15) with its index since note
// start; o_smp returns the sample scaled by the envelope gain and the
// segment code (attack, decay, sustain, release, finished). i_cfg writes the
// four segment lengths, counted in samples; index 0..3 selects attack, decay,
// sustain, release, other indexes are dropped. Write lengths only while idle.
// Throughput: one sample per cycle while the skid register is empty. Each
// result passes 3 decode stages, 17 divider stages - one per quotient
// bit of the Q0.16 gain plus the bit for exactly 1.0 - one multiply stage
// and one output register. The per-sample divide is what sets the depth.
// Reset clears all lengths to zero (every index reads as finished) and
// empties the pipeline. When the receiver stalls, the output register holds
// and one more result lands in a skid register; the pipeline then freezes
// as a whole and i_smp.ready drops until the skid register drains.
module adsr_envelope_gain #(
    parameter int SAMPLE_WIDTH = adsr_pkg::SAMPLE_WIDTH_DEF,
    parameter int INDEX_WIDTH  = adsr_pkg::INDEX_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    adsr_in_if.sink   i_smp,
    adsr_cfg_if.sink  i_cfg,
    adsr_out_if.source o_smp
);

    localparam int DW    = INDEX_WIDTH + 3;
    localparam int SEG_W = adsr_pkg::SEG_W;
    localparam int TAG_W = SEG_W + SAMPLE_WIDTH;

    logic [INDEX_WIDTH-1:0] attack_len;
    logic [INDEX_WIDTH-1:0] decay_len;
    logic [INDEX_WIDTH-1:0] sustain_len;
    logic [INDEX_WIDTH-1:0] release_len;

    // pipeline advance; frozen only while the skid register holds a result
    logic en;

    logic                           dec_v;
    logic [DW-1:0]                  dec_num;
    logic [DW-1:0]                  dec_den;
    logic [SEG_W-1:0]               dec_seg;
    logic signed [SAMPLE_WIDTH-1:0] dec_s;

    logic                           div_v;
    logic [adsr_pkg::QUOT_W-1:0]    div_q;
    logic [TAG_W-1:0]               div_tag;

    logic                           mul_v;
    logic signed [SAMPLE_WIDTH-1:0] mul_s;
    logic [SEG_W-1:0]               mul_seg;

    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_sample;
    logic [SEG_W-1:0]               r_out_seg;
    logic                           r_skid_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_skid_sample;
    logic [SEG_W-1:0]               r_skid_seg;

    assign en          = !r_skid_valid;
    assign i_smp.ready = en;

    adsr_cfg_regs #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (i_cfg),
        .o_attack_len  (attack_len),
        .o_decay_len   (decay_len),
        .o_sustain_len (sustain_len),
        .o_release_len (release_len)
    );

    adsr_seg_decode #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .INDEX_WIDTH  (INDEX_WIDTH)
    ) u_dec (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_smp.valid),
        .i_index       (i_smp.sample_index),
        .i_sample      (i_smp.sample_in),
        .i_attack_len  (attack_len),
        .i_decay_len   (decay_len),
        .i_sustain_len (sustain_len),
        .i_release_len (release_len),
        .o_valid       (dec_v),
        .o_num         (dec_num),
        .o_den         (dec_den),
        .o_seg         (dec_seg),
        .o_sample      (dec_s)
    );

    // segment and sample ride along the divider as a tag
    adsr_gain_div #(
        .DW    (DW),
        .TAG_W (TAG_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dec_v),
        .i_num   (dec_num),
        .i_den   (dec_den),
        .i_tag   ({dec_seg, dec_s}),
        .o_valid (div_v),
        .o_quot  (div_q),
        .o_tag   (div_tag)
    );

    adsr_scale #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (div_v),
        .i_quot   (div_q),
        .i_seg    (div_tag[TAG_W-1:SAMPLE_WIDTH]),
        .i_sample (div_tag[SAMPLE_WIDTH-1:0]),
        .o_valid  (mul_v),
        .o_sample (mul_s),
        .o_seg    (mul_seg)
    );

    // Output register plus skid register. A result leaving the multiply
    // stage goes to the output register when it is free or being drained,
    // otherwise into the skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (o_smp.ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= mul_v;
            end
        end else if (mul_v) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_smp.ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_sample <= r_skid_sample;
                r_out_seg    <= r_skid_seg;
            end else begin
                r_out_sample <= mul_s;
                r_out_seg    <= mul_seg;
            end
        end else if (mul_v && en) begin
            r_skid_sample <= mul_s;
            r_skid_seg    <= mul_seg;
        end
    end

    assign o_smp.valid      = r_out_valid;
    assign o_smp.sample_out = r_out_sample;
    assign o_smp.segment    = r_out_seg;

    // skid register only ever fills behind a waiting output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result with no output pending");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !o_smp.ready && mul_v))
        else $error("skid register filled without a stalled output");

    a_done_is_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_seg == adsr_pkg::SEG_DONE) |-> (r_out_sample == '0))
        else $error("finished segment produced a nonzero sample");

    a_no_skid_while_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !r_skid_valid) |=> !r_skid_valid)
        else $error("skid register filled while output register was free");

endmodule
